FILE: src/psc_pkg.sv
// Package for the palindromic substring counter.
// Holds request/result types, cell control struct, FSM states and saturating add.
// No dependencies.
package psc_pkg;

  localparam int CHAR_W      = 8;
  localparam int COUNT_W     = 12;
  localparam int MAX_LEN_DEF = 64;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              last_char;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] palindrome_count;
    logic               too_long;
  } rsp_t;

  typedef struct packed {
    logic              step;
    logic              drain;
    logic              clear;
    logic [CHAR_W-1:0] ch;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
  endfunction

endpackage

FILE: src/psc_cell.sv
// One cell of the palindrome chain: a stored byte, its ends-here flag and a hit counter.
// Depends on psc_pkg.
module psc_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  psc_pkg::cell_ctrl_t         ctrl,
  input  logic                        left_occ,
  input  logic                        right_occ,
  input  logic                        right_flag,
  input  logic [psc_pkg::COUNT_W-1:0] cnt_in,
  output logic                        occ,
  output logic                        flag,
  output logic [psc_pkg::COUNT_W-1:0] cnt
);

  logic [psc_pkg::CHAR_W-1:0] ch;
  logic                       hit;

  assign hit = (ch == ctrl.ch) && (!right_occ || right_flag);

  always_ff @(posedge clk) begin
    if (ctrl.step && !occ && left_occ) begin
      ch <= ctrl.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= 1'b0;
      flag <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.clear) begin
      occ  <= 1'b0;
      flag <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.drain) begin
      cnt <= cnt_in;
    end else if (ctrl.step) begin
      if (occ) begin
        flag <= hit;
        cnt  <= psc_pkg::sat_add(cnt, {{(psc_pkg::COUNT_W-1){1'b0}}, hit});
      end else if (left_occ) begin
        occ  <= 1'b1;
        flag <= 1'b1;
        cnt  <= psc_pkg::sat_add(cnt, {{(psc_pkg::COUNT_W-1){1'b0}}, 1'b1});
      end
    end
  end

endmodule

FILE: src/palindromic_substring_counter_unit.sv
// Palindromic substring counter: one byte per cycle while a string streams in.
// After the final byte, busy stays high while the cell counters shift into the total;
// done pulses for a single cycle as busy falls.
// result holds until the next drain updates it; the receiver cannot stall.
// Synchronous reset clears all cells, the counters and the overflow flag.
// Depends on psc_pkg and psc_cell.
module palindromic_substring_counter_unit #(
  parameter int MAX_LEN = psc_pkg::MAX_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  psc_pkg::req_t req,
  output logic          done,
  output psc_pkg::rsp_t result
);

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_LEN - 1);

  psc_pkg::state_t     state, state_next;
  psc_pkg::cell_ctrl_t ctrl;

  logic                        occ_v  [MAX_LEN];
  logic                        flag_v [MAX_LEN];
  logic [psc_pkg::COUNT_W-1:0] cnt_v  [MAX_LEN];

  logic [IDX_W-1:0]            idx;
  logic [psc_pkg::COUNT_W-1:0] total;
  logic [psc_pkg::COUNT_W-1:0] total_next;
  logic                        overflow;
  logic                        full;

  assign full       = occ_v[MAX_LEN-1];
  assign total_next = psc_pkg::sat_add(total, cnt_v[0]);

  genvar g;
  generate
    for (g = 0; g < MAX_LEN; g++) begin : g_cell
      logic                        left_occ;
      logic                        right_occ;
      logic                        right_flag;
      logic [psc_pkg::COUNT_W-1:0] cnt_in;

      if (g == 0) begin : g_first
        assign left_occ = 1'b1;
      end else begin : g_mid
        assign left_occ = occ_v[g-1];
      end

      if (g == MAX_LEN - 1) begin : g_tail
        assign right_occ  = 1'b0;
        assign right_flag = 1'b0;
        assign cnt_in     = '0;
      end else begin : g_body
        assign right_occ  = occ_v[g+1];
        assign right_flag = flag_v[g+1];
        assign cnt_in     = cnt_v[g+1];
      end

      psc_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .left_occ   (left_occ),
        .right_occ  (right_occ),
        .right_flag (right_flag),
        .cnt_in     (cnt_in),
        .occ        (occ_v[g]),
        .flag       (flag_v[g]),
        .cnt        (cnt_v[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    ctrl.step  = 1'b0;
    ctrl.drain = 1'b0;
    ctrl.clear = 1'b0;
    ctrl.ch    = req.char_in;
    unique case (state)
      psc_pkg::ST_IDLE: begin
        if (start) begin
          ctrl.step = !full;
          if (req.last_char) begin
            state_next = psc_pkg::ST_DRAIN;
          end
        end
      end
      psc_pkg::ST_DRAIN: begin
        busy       = 1'b1;
        ctrl.drain = 1'b1;
        if (idx == LAST_IDX) begin
          ctrl.clear = 1'b1;
          state_next = psc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = psc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      total    <= '0;
      overflow <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (state == psc_pkg::ST_IDLE) begin
        if (start) begin
          if (full) begin
            overflow <= 1'b1;
          end
          if (req.last_char) begin
            idx   <= '0;
            total <= '0;
          end
        end
      end else begin
        total <= total_next;
        idx   <= idx + 1'b1;
        if (idx == LAST_IDX) begin
          done     <= 1'b1;
          overflow <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == psc_pkg::ST_DRAIN && idx == LAST_IDX) begin
      result.palindrome_count <= total_next;
      result.too_long         <= overflow;
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for palindromic_substring_counter_unit: streams strings, predicts each count.
// Depends on psc_pkg and the RTL of the counter unit.
module tb;

  localparam int STR_CAP     = psc_pkg::MAX_LEN_DEF;
  localparam int RAND_CHARS  = 1900;
  localparam int CYCLE_LIMIT = 400000;

  class palindrome_scoreboard;
    logic [psc_pkg::CHAR_W-1:0]  text [STR_CAP];
    bit                          ends_at_tail [STR_CAP];
    int unsigned                 stored;
    logic [psc_pkg::COUNT_W-1:0] tally;
    bit                          dropped;
    psc_pkg::rsp_t               expected_q [$];
    int                          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      foreach (ends_at_tail[i]) ends_at_tail[i] = 1'b0;
      stored  = 0;
      tally   = '0;
      dropped = 1'b0;
    endfunction

    // Extend only palindromes ending at the previous char that the new char mirrors.
    function void absorb_char(logic [psc_pkg::CHAR_W-1:0] c);
      int unsigned gained;
      int unsigned sum;
      int unsigned i;
      bit          inner_ok;
      bit          hit;
      gained = 1;
      for (i = 0; i < stored; i++) begin
        inner_ok = (i + 1 >= stored) ? 1'b1 : ends_at_tail[i + 1];
        hit = (text[i] == c) && inner_ok;
        ends_at_tail[i] = hit;
        if (hit) gained++;
      end
      text[stored] = c;
      ends_at_tail[stored] = 1'b1;
      stored++;
      sum = tally + gained;
      tally = (sum > psc_pkg::COUNT_MAX) ? psc_pkg::COUNT_MAX : sum[psc_pkg::COUNT_W-1:0];
    endfunction

    function void note_request(psc_pkg::req_t r);
      psc_pkg::rsp_t exp_rsp;
      if (stored < STR_CAP) absorb_char(r.char_in);
      else dropped = 1'b1;
      if (r.last_char) begin
        exp_rsp.palindrome_count = tally;
        exp_rsp.too_long = dropped;
        expected_q.push_back(exp_rsp);
        restart();
      end
    endfunction

    function void check_result(psc_pkg::rsp_t got);
      psc_pkg::rsp_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result count=%0d too_long=%0b",
                 $time, got.palindrome_count, got.too_long);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.palindrome_count !== want.palindrome_count) begin
        $display("%0t: palindrome_count mismatch expected %0d actual %0d",
                 $time, want.palindrome_count, got.palindrome_count);
        errors++;
      end
      if (got.too_long !== want.too_long) begin
        $display("%0t: too_long mismatch expected %0b actual %0b",
                 $time, want.too_long, got.too_long);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst;
  logic          start;
  logic          busy;
  psc_pkg::req_t req;
  logic          done;
  psc_pkg::rsp_t result;

  palindrome_scoreboard board = new();
  int unsigned cycle_count = 0;
  bit          no_gaps = 1'b0;

  palindromic_substring_counter_unit #(
    .MAX_LEN(STR_CAP)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  // Enter and leave at a falling edge.
  task automatic send_char(input logic [psc_pkg::CHAR_W-1:0] c, input bit fin);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    req.char_in <= c;
    req.last_char <= fin;
    do @(posedge clk); while (busy);
    board.note_request(req);
    @(negedge clk);
  endtask

  task automatic send_string(input logic [psc_pkg::CHAR_W-1:0] s [$]);
    no_gaps = ($urandom_range(0, 3) == 0);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  // Hold off until every pending count has come back.
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
  endtask

  initial begin
    logic [psc_pkg::CHAR_W-1:0] s [$];
    logic [psc_pkg::CHAR_W-1:0] a;
    logic [psc_pkg::CHAR_W-1:0] b;
    logic [psc_pkg::CHAR_W-1:0] d;
    int sent;
    int len;
    int kind;
    int pick;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    s = '{8'h00};                          send_string(s);
    s = '{8'hFF};                          send_string(s);
    s = '{8'h5A, 8'h5A};                   send_string(s);
    s = '{8'h01, 8'h02};                   send_string(s);
    s = '{8'h61, 8'h62, 8'h63, 8'h62, 8'h61}; send_string(s);
    s = '{8'hA5, 8'h5A, 8'hA5, 8'h5A};     send_string(s);
    s.delete();
    repeat (STR_CAP) s.push_back(8'h33);
    send_string(s);
    s.delete();
    for (int i = 0; i < STR_CAP + 2; i++) s.push_back((i % 2) ? 8'h7F : 8'h80);
    send_string(s);
    settle();

    sent = 0;
    while (sent < RAND_CHARS) begin
      s.delete();
      pick = $urandom_range(0, 99);
      if (pick < 70) len = $urandom_range(1, 12);
      else if (pick < 90) len = $urandom_range(13, STR_CAP - 1);
      else if (pick < 96) len = STR_CAP;
      else len = $urandom_range(STR_CAP + 1, STR_CAP + 16);
      kind = $urandom_range(0, 9);
      a = 8'($urandom);
      b = 8'($urandom);
      d = 8'($urandom);
      for (int i = 0; i < len; i++) begin
        if (kind <= 4) s.push_back($urandom_range(0, 1) ? a : b);
        else if (kind <= 6) begin
          pick = $urandom_range(0, 2);
          s.push_back(pick == 0 ? a : (pick == 1 ? b : d));
        end else if (kind <= 8) s.push_back(8'($urandom));
        else if (i < (len + 1) / 2) s.push_back($urandom_range(0, 1) ? a : b);
        else s.push_back(s[len - 1 - i]);
      end
      send_string(s);
      sent += len;
      if ($urandom_range(0, 19) == 0) settle();
    end

    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (STR_CAP + 10) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
